>>> rtl/ucal_pkg.sv
// Shared types and constants for the seconds-to-calendar converter.
// Used by ucal_front, ucal_queue, ucal_back and the top level; no dependencies.
`default_nettype none

package ucal_pkg;

   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int EPOCH_YEAR    = 1970;
   localparam int LAST_YEAR     = 2106;

   localparam int SECONDS_W = 32;
   localparam int DAYS_W    = 16;
   localparam int YEAR_W    = 12;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SECOND_W  = 6;
   localparam int RSP_DATA_W = 40;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR_VAL = YEAR_W'(EPOCH_YEAR);
   localparam logic [1:0]        EPOCH_MOD4     = 2'(EPOCH_YEAR % 4);
   localparam logic [6:0]        EPOCH_MOD100   = 7'(EPOCH_YEAR % 100);
   localparam logic [8:0]        EPOCH_MOD400   = 9'(EPOCH_YEAR % 400);

   localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;
   localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;

   // Reciprocals for the odd parts of the constant divisors. A day is 128 * 675
   // seconds, an hour 16 * 225 and a minute 4 * 15; each value is the ceiling of
   // 2^35 / 675, 2^21 / 225 and 2^14 / 15, exact over the shifted input range.
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [10:0] MIN_RECIP  = 11'd1093;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd5;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd8;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd10;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One day's split: whole days since the epoch and the time of day.
   typedef struct packed {
      logic [DAYS_W-1:0]   days;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } span_type;

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_DAY,
      FRONT_DAY_REM,
      FRONT_HOUR,
      FRONT_HOUR_REM,
      FRONT_MIN,
      FRONT_MIN_REM,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_LOAD,
      BACK_YEAR,
      BACK_MONTH,
      BACK_DONE
   } back_state_type;

   // Length of a month, counted from January as zero.
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mon,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (mon)
         MONTH_FEB: begin
            len = leap ? 5'd29 : 5'd28;
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ucal_front.sv
// Front part: accepts a request and splits the seconds into days, hours,
// minutes and seconds with reciprocal multiplications. Uses ucal_pkg.
`default_nettype none

module ucal_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ucal_pkg::SECONDS_W-1:0]       req_tdata,
   output logic                                      push,
   output ucal_pkg::span_type                        push_data,
   input  wire logic                                 queue_full
);

   ucal_pkg::front_state_type state_ff, state_in;

   logic [ucal_pkg::SECONDS_W-1:0] rem_ff, rem_in;
   logic [ucal_pkg::DAYS_W-1:0]    days_ff, days_in;
   logic [ucal_pkg::HOUR_W-1:0]    hour_ff, hour_in;
   logic [ucal_pkg::MINUTE_W-1:0]  minute_ff, minute_in;

   logic [50:0] day_prod;
   logic [26:0] hour_prod;
   logic [20:0] min_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ucal_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      days_ff   <= days_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
   end

   // The power-of-two part of each divisor is shifted off first, and the odd
   // part is divided by multiplying with its scaled reciprocal.
   assign day_prod  = 51'(rem_ff[ucal_pkg::SECONDS_W-1:7]) * 51'(ucal_pkg::DAY_RECIP);
   assign hour_prod = 27'(rem_ff[16:4]) * 27'(ucal_pkg::HOUR_RECIP);
   assign min_prod  = 21'(rem_ff[11:2]) * 21'(ucal_pkg::MIN_RECIP);

   assign push_data.days   = days_ff;
   assign push_data.hour   = hour_ff;
   assign push_data.minute = minute_ff;
   assign push_data.second = rem_ff[ucal_pkg::SECOND_W-1:0];

   always_comb begin
      state_in   = state_ff;
      rem_in     = rem_ff;
      days_in    = days_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      req_tready = 1'b0;
      push       = 1'b0;
      unique case (state_ff)
         ucal_pkg::FRONT_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rem_in   = req_tdata;
               state_in = ucal_pkg::FRONT_DAY;
            end
         end
         ucal_pkg::FRONT_DAY: begin
            days_in  = day_prod[50:35];
            state_in = ucal_pkg::FRONT_DAY_REM;
         end
         ucal_pkg::FRONT_DAY_REM: begin
            rem_in   = rem_ff - ucal_pkg::SECONDS_W'(days_ff) *
                               ucal_pkg::SECONDS_W'(ucal_pkg::SECS_PER_DAY);
            state_in = ucal_pkg::FRONT_HOUR;
         end
         ucal_pkg::FRONT_HOUR: begin
            hour_in  = ucal_pkg::HOUR_W'(hour_prod[26:21]);
            state_in = ucal_pkg::FRONT_HOUR_REM;
         end
         ucal_pkg::FRONT_HOUR_REM: begin
            rem_in   = rem_ff - ucal_pkg::SECONDS_W'(hour_ff) *
                               ucal_pkg::SECONDS_W'(ucal_pkg::SECS_PER_HOUR);
            state_in = ucal_pkg::FRONT_MIN;
         end
         ucal_pkg::FRONT_MIN: begin
            minute_in = ucal_pkg::MINUTE_W'(min_prod[20:14]);
            state_in  = ucal_pkg::FRONT_MIN_REM;
         end
         ucal_pkg::FRONT_MIN_REM: begin
            rem_in   = rem_ff - ucal_pkg::SECONDS_W'(minute_ff) *
                               ucal_pkg::SECONDS_W'(ucal_pkg::SECS_PER_MIN);
            state_in = ucal_pkg::FRONT_PUSH;
         end
         ucal_pkg::FRONT_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = ucal_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = ucal_pkg::FRONT_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_time_of_day_range: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_data.hour < 5'd24 && push_data.minute < 6'd60 &&
                rem_ff < ucal_pkg::SECONDS_W'(ucal_pkg::SECS_PER_MIN)))
      else $error("time of day out of range at push");
   a_accept_starts_day: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ucal_pkg::FRONT_DAY))
      else $error("accepted request did not start the day division");
`endif

endmodule

`default_nettype wire

>>> rtl/ucal_queue.sv
// Short queue between the divider front part and the calendar back part.
// Read data is registered on a pop and is valid in the cycle after it. Uses ucal_pkg.
`default_nettype none

module ucal_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ucal_pkg::span_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output ucal_pkg::span_type      rd_data
);

   ucal_pkg::span_type mem [ucal_pkg::QUEUE_DEPTH];
   ucal_pkg::span_type rd_data_ff;

   logic [ucal_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ucal_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ucal_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   localparam logic [ucal_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      ucal_pkg::QUEUE_PTR_W'(ucal_pkg::QUEUE_DEPTH - 1);

   assign full    = (count_ff == ucal_pkg::QUEUE_CNT_W'(ucal_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = rd_data_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (do_pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ucal_pkg::QUEUE_CNT_W'(ucal_pkg::QUEUE_DEPTH))
      else $error("queue count exceeds depth");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");
`endif

endmodule

`default_nettype wire

>>> rtl/ucal_back.sv
// Back part: takes whole years, then whole months, off the day count and
// holds the finished date in the result register. Uses ucal_pkg.
`default_nettype none

module ucal_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              queue_empty,
   output logic                                   pop,
   input  wire ucal_pkg::span_type                rd_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ucal_pkg::YEAR_W-1:0]            rsp_year,
   output logic [ucal_pkg::MONTH_W-1:0]           rsp_month,
   output logic [ucal_pkg::DAY_W-1:0]             rsp_day,
   output logic [ucal_pkg::HOUR_W-1:0]            rsp_hour,
   output logic [ucal_pkg::MINUTE_W-1:0]          rsp_minute,
   output logic [ucal_pkg::SECOND_W-1:0]          rsp_second
);

   ucal_pkg::back_state_type state_ff, state_in;

   logic [ucal_pkg::DAYS_W-1:0]   days_ff, days_in;
   logic [ucal_pkg::YEAR_W-1:0]   year_ff, year_in;
   logic [1:0]                    mod4_ff, mod4_in;
   logic [6:0]                    mod100_ff, mod100_in;
   logic [8:0]                    mod400_ff, mod400_in;
   logic [ucal_pkg::MONTH_W-1:0]  mon_ff, mon_in;
   logic [ucal_pkg::HOUR_W-1:0]   hour_ff, hour_in;
   logic [ucal_pkg::MINUTE_W-1:0] minute_ff, minute_in;
   logic [ucal_pkg::SECOND_W-1:0] second_ff, second_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ucal_pkg::YEAR_W-1:0]   rsp_year_ff, rsp_year_in;
   logic [ucal_pkg::MONTH_W-1:0]  rsp_month_ff, rsp_month_in;
   logic [ucal_pkg::DAY_W-1:0]    rsp_day_ff, rsp_day_in;
   logic [ucal_pkg::HOUR_W-1:0]   rsp_hour_ff, rsp_hour_in;
   logic [ucal_pkg::MINUTE_W-1:0] rsp_minute_ff, rsp_minute_in;
   logic [ucal_pkg::SECOND_W-1:0] rsp_second_ff, rsp_second_in;

   logic                          leap;
   logic [8:0]                    year_len;
   logic [ucal_pkg::DAY_W-1:0]    mon_len;
   logic                          rsp_free;

   // Leap rule from running remainders of the year, so no division is needed.
   assign leap     = (mod4_ff == 2'd0) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));
   assign year_len = leap ? ucal_pkg::DAYS_LEAP_YEAR : ucal_pkg::DAYS_COMMON_YEAR;
   assign mon_len  = ucal_pkg::month_days(mon_ff, leap);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ucal_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      days_ff       <= days_in;
      year_ff       <= year_in;
      mod4_ff       <= mod4_in;
      mod100_ff     <= mod100_in;
      mod400_ff     <= mod400_in;
      mon_ff        <= mon_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      second_ff     <= second_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_second_ff <= rsp_second_in;
   end

   always_comb begin
      state_in      = state_ff;
      days_in       = days_ff;
      year_in       = year_ff;
      mod4_in       = mod4_ff;
      mod100_in     = mod100_ff;
      mod400_in     = mod400_ff;
      mon_in        = mon_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      second_in     = second_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_second_in = rsp_second_ff;
      pop           = 1'b0;
      unique case (state_ff)
         ucal_pkg::BACK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               state_in = ucal_pkg::BACK_LOAD;
            end
         end
         ucal_pkg::BACK_LOAD: begin
            days_in   = rd_data.days;
            hour_in   = rd_data.hour;
            minute_in = rd_data.minute;
            second_in = rd_data.second;
            year_in   = ucal_pkg::EPOCH_YEAR_VAL;
            mod4_in   = ucal_pkg::EPOCH_MOD4;
            mod100_in = ucal_pkg::EPOCH_MOD100;
            mod400_in = ucal_pkg::EPOCH_MOD400;
            mon_in    = ucal_pkg::MONTH_JAN;
            state_in  = ucal_pkg::BACK_YEAR;
         end
         ucal_pkg::BACK_YEAR: begin
            if (days_ff < ucal_pkg::DAYS_W'(year_len)) begin
               state_in = ucal_pkg::BACK_MONTH;
            end else begin
               days_in   = days_ff - ucal_pkg::DAYS_W'(year_len);
               year_in   = year_ff + 1'b1;
               mod4_in   = mod4_ff + 1'b1;
               mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 1'b1;
               mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 1'b1;
            end
         end
         ucal_pkg::BACK_MONTH: begin
            if (mon_ff == ucal_pkg::MONTH_DEC || days_ff < ucal_pkg::DAYS_W'(mon_len)) begin
               state_in = ucal_pkg::BACK_DONE;
            end else begin
               days_in = days_ff - ucal_pkg::DAYS_W'(mon_len);
               mon_in  = mon_ff + 1'b1;
            end
         end
         ucal_pkg::BACK_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_year_in   = year_ff;
               rsp_month_in  = mon_ff + 1'b1;
               rsp_day_in    = days_ff[ucal_pkg::DAY_W-1:0] + 1'b1;
               rsp_hour_in   = hour_ff;
               rsp_minute_in = minute_ff;
               rsp_second_in = second_ff;
               state_in      = ucal_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = ucal_pkg::BACK_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_year   = rsp_year_ff;
   assign rsp_month  = rsp_month_ff;
   assign rsp_day    = rsp_day_ff;
   assign rsp_hour   = rsp_hour_ff;
   assign rsp_minute = rsp_minute_ff;
   assign rsp_second = rsp_second_ff;

`ifndef SYNTHESIS
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ucal_pkg::BACK_DONE && rsp_free) |->
         (year_ff <= ucal_pkg::YEAR_W'(ucal_pkg::LAST_YEAR) &&
          mon_ff <= ucal_pkg::MONTH_DEC && days_ff < 16'd31))
      else $error("finished date out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/unix_seconds_to_calendar_date.sv
// Top level of the seconds-to-calendar converter: ucal_front, ucal_queue and
// ucal_back joined into one stream block. Uses ucal_pkg.
`default_nettype none

// A request carries an unsigned 32-bit count of seconds since 1970-01-01
// 00:00:00, and each request yields exactly one response with the Gregorian
// year, month (1 to 12), day of the month (1 to 31) and the hour, minute and
// second of the day. The largest input, all ones, gives 2106-02-07 06:28:15.
// The front part splits the seconds into whole days and time of day by
// dividing by the constant day, hour and minute lengths with reciprocal
// multiplications: after the accepting state it takes a quotient step and
// then a remainder step for each length, and then hands the result into the
// queue, waiting there while the queue is full. The back part then steps
// through the years one per cycle from 1970 (up to 136 steps) and through
// the months one per cycle (up to 11), and that year walk sets the sustained
// rate for late dates. A two-entry queue between the two parts lets the
// front part take and divide the next request while the back part is still
// walking the calendar, and the response register lets the back part start
// on the next day count while a finished response waits to be taken.
// Nothing is kept from one request to the next; reset only clears the
// control state, and there are no configuration registers.

module unix_seconds_to_calendar_date (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // [31:0] unix_seconds
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata     // [11:0] year, [15:12] month, [20:16] day,
                                          // [25:21] hour, [31:26] minute,
                                          // [37:32] second, [39:38] zero
);

   logic               push;
   ucal_pkg::span_type push_data;
   logic               queue_full;
   logic               pop;
   logic               queue_empty;
   ucal_pkg::span_type rd_data;

   logic [ucal_pkg::YEAR_W-1:0]   rsp_year;
   logic [ucal_pkg::MONTH_W-1:0]  rsp_month;
   logic [ucal_pkg::DAY_W-1:0]    rsp_day;
   logic [ucal_pkg::HOUR_W-1:0]   rsp_hour;
   logic [ucal_pkg::MINUTE_W-1:0] rsp_minute;
   logic [ucal_pkg::SECOND_W-1:0] rsp_second;

   // Front part: takes a request whenever its divider is free.
   ucal_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // Queue of day counts and times of day waiting for the calendar walk.
   ucal_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .rd_data   (rd_data)
   );

   // Back part: year and month walk plus the response register.
   ucal_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_year    (rsp_year),
      .rsp_month   (rsp_month),
      .rsp_day     (rsp_day),
      .rsp_hour    (rsp_hour),
      .rsp_minute  (rsp_minute),
      .rsp_second  (rsp_second)
   );

   // Response fields packed from the lowest bit up, padded to whole bytes.
   assign rsp_tdata = {2'b00, rsp_second, rsp_minute, rsp_hour, rsp_day, rsp_month, rsp_year};

endmodule

`default_nettype wire

>>> sim/unix_seconds_to_calendar_date_checker.sv
// Checker for the seconds-to-calendar converter: watches both stream channels, predicts
// each request's calendar date and compares it with the response.
// Depends on ucal_pkg for the field widths.
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [ucal_pkg::SECONDS_W-1:0]  req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [ucal_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                                   date_errors,
   output int                                   dates_pending,
   output int                                   dates_checked
);

   typedef struct packed {
      logic [ucal_pkg::SECONDS_W-1:0] seconds;
      logic [ucal_pkg::YEAR_W-1:0]    year;
      logic [ucal_pkg::MONTH_W-1:0]   month;
      logic [ucal_pkg::DAY_W-1:0]     day;
      logic [ucal_pkg::HOUR_W-1:0]    hour;
      logic [ucal_pkg::MINUTE_W-1:0]  minute;
      logic [ucal_pkg::SECOND_W-1:0]  second;
   } date_stamp_type;

   date_stamp_type expected_dates[$];
   date_stamp_type oldest_date;

   initial begin
      date_errors   = 0;
      dates_pending = 0;
      dates_checked = 0;
   end

   function automatic bit leap_year(input int unsigned yr);
      return ((yr % 4) == 0) && (((yr % 100) != 0) || ((yr % 400) == 0));
   endfunction

   // Month index counts from zero for January.
   function automatic int unsigned month_length(input int unsigned idx, input bit leap);
      int unsigned len;
      case (idx)
         1: begin
            len = leap ? 29 : 28;
         end
         3, 5, 8, 10: begin
            len = 30;
         end
         default: begin
            len = 31;
         end
      endcase
      return len;
   endfunction

   function automatic date_stamp_type seconds_to_date(
      input logic [ucal_pkg::SECONDS_W-1:0] secs);
      date_stamp_type stamp;
      int unsigned day_count;
      int unsigned day_secs;
      int unsigned yr;
      int unsigned mon;
      int unsigned year_len;
      bit leap;
      day_count = secs / ucal_pkg::SECS_PER_DAY;
      day_secs  = secs % ucal_pkg::SECS_PER_DAY;
      yr = ucal_pkg::EPOCH_YEAR;
      year_len = leap_year(yr) ? 366 : 365;
      while (day_count >= year_len) begin
         day_count = day_count - year_len;
         yr = yr + 1;
         year_len = leap_year(yr) ? 366 : 365;
      end
      leap = leap_year(yr);
      mon = 0;
      while (mon < 11 && day_count >= month_length(mon, leap)) begin
         day_count = day_count - month_length(mon, leap);
         mon = mon + 1;
      end
      stamp.seconds = secs;
      stamp.year    = ucal_pkg::YEAR_W'(yr);
      stamp.month   = ucal_pkg::MONTH_W'(mon + 1);
      stamp.day     = ucal_pkg::DAY_W'(day_count + 1);
      stamp.hour    = ucal_pkg::HOUR_W'(day_secs / ucal_pkg::SECS_PER_HOUR);
      stamp.minute  = ucal_pkg::MINUTE_W'((day_secs % ucal_pkg::SECS_PER_HOUR) /
                                          ucal_pkg::SECS_PER_MIN);
      stamp.second  = ucal_pkg::SECOND_W'(day_secs % ucal_pkg::SECS_PER_MIN);
      return stamp;
   endfunction

   task automatic check_field(input string name,
                              input logic [ucal_pkg::SECONDS_W-1:0] secs,
                              input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch for %0d seconds: expected %0d, actual %0d",
                name, secs, want, got);
         date_errors = date_errors + 1;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_dates.push_back(seconds_to_date(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dates.size() == 0) begin
               $error("response %h arrived with no request outstanding", rsp_tdata);
               date_errors = date_errors + 1;
            end else begin
               oldest_date = expected_dates.pop_front();
               check_field("year", oldest_date.seconds, 32'(oldest_date.year),
                           32'(rsp_tdata[11:0]));
               check_field("month", oldest_date.seconds, 32'(oldest_date.month),
                           32'(rsp_tdata[15:12]));
               check_field("day", oldest_date.seconds, 32'(oldest_date.day),
                           32'(rsp_tdata[20:16]));
               check_field("hour", oldest_date.seconds, 32'(oldest_date.hour),
                           32'(rsp_tdata[25:21]));
               check_field("minute", oldest_date.seconds, 32'(oldest_date.minute),
                           32'(rsp_tdata[31:26]));
               check_field("second", oldest_date.seconds, 32'(oldest_date.second),
                           32'(rsp_tdata[37:32]));
               check_field("padding", oldest_date.seconds, 32'd0,
                           32'(rsp_tdata[39:38]));
               dates_checked = dates_checked + 1;
            end
         end
         dates_pending = expected_dates.size();
      end
   end

endmodule

>>> sim/tb_unix_seconds_to_calendar_date.sv
// Testbench top for the seconds-to-calendar converter: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict.
// Depends on ucal_pkg, the block and unix_seconds_to_calendar_date_checker.
`timescale 1ns / 1ps

module tb_unix_seconds_to_calendar_date;

   // Longest stretch with no accepted request or response before the run is
   // declared hung. The deliberate hold-off below is well under it, and so is
   // the slowest request behind the heaviest stalling.
   localparam int WATCHDOG_LIMIT = 5000;
   // Length of the deliberate response hold-off, long enough for the front
   // part, the queue, the back part and the response register to all fill.
   localparam int HOLD_OFF_CYCLES = 700;
   // Random requests in each of the four idling phases.
   localparam int PHASE_REQUESTS = 320;
   // Quiet time after the last response, a little over the worst latency.
   localparam int DRAIN_CYCLES = 200;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ucal_pkg::SECONDS_W-1:0]  req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ucal_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int date_errors;
   int dates_pending;
   int dates_checked;

   // Idling percentages for the current phase, read by the sender task and
   // the response process.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // Handshake between the main sequence and the response process for the
   // long hold-off.
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;

   int requests_sent = 0;
   int quiet_cycles = 0;

   unix_seconds_to_calendar_date u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   unix_seconds_to_calendar_date_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .date_errors   (date_errors),
      .dates_pending (dates_pending),
      .dates_checked (dates_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side. Ready changes only at the falling edge. When the main
   // sequence asks for a hold-off, ready stays low for the whole hold-off,
   // which is counted here, while requests keep arriving and back up into the
   // block until it drops its own ready.
   always begin
      @(negedge clock);
      if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_OFF_CYCLES) @(negedge clock);
         hold_done = 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog: counts cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles with no transfer", WATCHDOG_LIMIT);
         $display("unix_seconds_to_calendar_date test failed");
         $finish;
      end
   end

   // Offers one request. Called at a falling edge and returns at the falling
   // edge after the request was taken, so valid stays up for back-to-back
   // requests without being dropped in between.
   task automatic send_seconds(input logic [ucal_pkg::SECONDS_W-1:0] secs);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= secs;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      requests_sent = requests_sent + 1;
      @(negedge clock);
   endtask

   // Random timestamps: half uniform over the whole 32-bit range, some in
   // the first 366 days (short calendar walk), the rest within two seconds of a
   // midnight anywhere in the range, which lands on month and year edges.
   function automatic logic [ucal_pkg::SECONDS_W-1:0] pick_seconds();
      int unsigned choice;
      logic [ucal_pkg::SECONDS_W-1:0] midnight;
      choice = $urandom_range(0, 9);
      midnight = ucal_pkg::SECONDS_W'($urandom_range(0, 49710)) *
                 ucal_pkg::SECONDS_W'(ucal_pkg::SECS_PER_DAY);
      if (choice < 5) begin
         return $urandom();
      end else if (choice < 7) begin
         return $urandom_range(0, 31622399);
      end
      return midnight + ucal_pkg::SECONDS_W'($urandom_range(0, 4)) -
             ucal_pkg::SECONDS_W'(2);
   endfunction

   task automatic run_phase(input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (PHASE_REQUESTS) begin
         send_seconds(pick_seconds());
      end
   endtask

   initial begin
      int held_requests;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests with no idling: the epoch and field edges of the
      // time of day, leap days in 1972 and 2000, the skipped leap day of
      // 2100, year ends, the signed 32-bit rollover and the largest input.
      send_seconds(32'd0);
      send_seconds(32'd1);
      send_seconds(32'd59);
      send_seconds(32'd60);
      send_seconds(32'd3599);
      send_seconds(32'd3600);
      send_seconds(32'd86399);
      send_seconds(32'd86400);
      send_seconds(32'd31535999);
      send_seconds(32'd68169599);
      send_seconds(32'd68169600);
      send_seconds(32'd68256000);
      send_seconds(32'd94694399);
      send_seconds(32'd946684799);
      send_seconds(32'd951782400);
      send_seconds(32'd978307199);
      send_seconds(32'd978307200);
      send_seconds(32'h7FFF_FFFF);
      send_seconds(32'h8000_0000);
      send_seconds(32'd4107542399);
      send_seconds(32'd4107542400);
      send_seconds(32'hAAAA_AAAA);
      send_seconds(32'h5555_5555);
      send_seconds(32'hFFFF_FFFF);

      // Random requests under the four idling patterns.
      run_phase(0, 0);
      run_phase(88, 0);
      run_phase(0, 88);
      run_phase(6, 6);

      // Back-pressure: the response side holds off while early dates keep
      // coming; the requests stall once every stage of the block is full.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 1'b1;
      held_requests = 0;
      while (!hold_done || held_requests < 24) begin
         send_seconds($urandom_range(0, 5000000));
         held_requests = held_requests + 1;
      end
      hold_request = 1'b0;
      req_tvalid <= 1'b0;

      while (dates_pending != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d timestamps from 1970 up to the 2106 limit, %0d responses checked,",
               requests_sent, dates_checked);
      $display("under free-running, idle-sender, stalled-receiver, light and held-off traffic.");
      if (date_errors == 0 && dates_pending == 0) begin
         $display("unix_seconds_to_calendar_date test passed");
      end else begin
         $display("unix_seconds_to_calendar_date test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/ucal_pkg.sv
rtl/ucal_front.sv
rtl/ucal_queue.sv
rtl/ucal_back.sv
rtl/unix_seconds_to_calendar_date.sv
sim/unix_seconds_to_calendar_date_checker.sv
sim/tb_unix_seconds_to_calendar_date.sv
